// File: rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and the rounding function of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

   localparam int MaxWidth  = 1024;
   localparam int AddrW     = $clog2(MaxWidth);
   localparam int ColW      = $clog2(MaxWidth + 1);

   localparam logic [0:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_FRAME_HEIGHT = 1'b1;

   typedef logic [23:0] pixel_type;

   // one blur request handed to the lanes
   typedef struct packed {
      logic [1:0] rlo;
      logic [1:0] clo;
      logic       run_last;
      logic       frame_end;
   } job_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       run_last;
      logic       frame_end;
   } result_type;

   // rounded mean of s over n in {1,2,3,4,6,9}: (2s+n)/(2n), s <= 2295
   function automatic logic [7:0] round_mean(input logic [11:0] s, input logic [3:0] n);
      logic [12:0] t;
      logic [25:0] p;
      logic [12:0] q;
      t = {s, 1'b0} + 13'(n);
      q = '0;
      p = '0;
      case (n)
         4'd1: q = t >> 1;
         4'd2: q = t >> 2;
         4'd4: q = t >> 3;
         4'd3: begin
            p = 26'(t) * 26'd5462;
            q = 13'(p >> 15);
         end
         4'd6: begin
            p = 26'(t) * 26'd5462;
            q = 13'(p >> 16);
         end
         4'd9: begin
            p = 26'(t) * 26'd7282;
            q = 13'(p >> 17);
         end
         default: q = '0;
      endcase
      round_mean = (q > 13'd255) ? 8'd255 : q[7:0];
   endfunction

endpackage

// File: rtl/bb3_if.sv
// ----------------------------------------------------------------------------
// bb3 stream interfaces
// Valid/ready channels for pixels, results and register writes.
// ----------------------------------------------------------------------------
interface bb3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_red;
   logic [7:0] in_green;
   logic [7:0] in_blue;
   modport source (output valid, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface bb3_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       run_last;
   logic       frame_end;
   modport source (output valid, out_red, out_green, out_blue, run_last, frame_end,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, run_last, frame_end,
                   output ready);
endinterface

interface bb3_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/bb3_lane.sv
// ----------------------------------------------------------------------------
// bb3_lane
// One color channel: masked window sum, then rounded mean.
// ----------------------------------------------------------------------------
module bb3_lane (
   input  logic       clock,
   input  logic       start,
   input  logic [7:0] win [9],
   input  logic [1:0] rlo,
   input  logic [1:0] clo,
   output logic [7:0] mean
);
   logic [11:0] sum_ff, sum_in;
   logic [3:0]  cnt_ff, cnt_in;

   always_comb begin
      sum_in = '0;
      cnt_in = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (2'(r) >= rlo && 2'(c) >= clo) begin
               sum_in = sum_in + 12'(win[r * 3 + c]);
               cnt_in = cnt_in + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

   assign mean = bb3_pkg::round_mean(sum_ff, cnt_ff);
endmodule

// File: rtl/bb3_merge.sv
// ----------------------------------------------------------------------------
// bb3_merge
// Joins the three lane means with the flags into one output word.
// ----------------------------------------------------------------------------
module bb3_merge (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [7:0]           red,
   input  logic [7:0]           green,
   input  logic [7:0]           blue,
   input  bb3_pkg::job_type     job,
   bb3_rsp_if.source            rsp
);
   bb3_pkg::result_type res_ff;
   logic                valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         res_ff <= '{red: red, green: green, blue: blue,
                     run_last: job.run_last, frame_end: job.frame_end};
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.out_red   = res_ff.red;
   assign rsp.out_green = res_ff.green;
   assign rsp.out_blue  = res_ff.blue;
   assign rsp.run_last  = res_ff.run_last;
   assign rsp.frame_end = res_ff.frame_end;
endmodule

// File: rtl/box_blur_3x3_rgb.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box blur over RGB pixels in raster order.
// ----------------------------------------------------------------------------
// A pixel is taken while the sequencer is idle, and both line stores are read
// as it is taken; the next cycle shifts the window and moves the middle row
// entry up. Each result it causes (up to four) then goes through the three
// per-channel lane sums, which are registered, and then the rounded mean into
// the output word. Once no result is pending, the sequencer goes idle. A
// result waits while the output word is still held; a stalled word delays the
// next result. Any register write restarts the frame at row 0, column 0.
module box_blur_3x3_rgb (
   input  logic        clock,
   input  logic        reset,
   bb3_req_if.sink     req,
   bb3_rsp_if.source   rsp,
   bb3_csr_if.sink     csr
);
   localparam int AW = bb3_pkg::AddrW;
   localparam int CW = bb3_pkg::ColW;

   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [CW-1:0] wmax;
   logic [15:0] hmax;
   logic [CW-1:0] col_ff;
   logic [15:0]   row_ff;

   bb3_pkg::pixel_type upper_mem [bb3_pkg::MaxWidth];
   bb3_pkg::pixel_type middle_mem [bb3_pkg::MaxWidth];
   bb3_pkg::pixel_type up_rd_ff, mid_rd_ff, pix_ff;
   bb3_pkg::pixel_type win_ff [9];
   logic [AW-1:0]      addr_ff;

   // sequencer: idle, window shift, then jobs
   logic        busy_ff, shift_ff;
   logic [3:0]  pend_ff;
   logic        calc_ff;
   bb3_pkg::job_type jobs_ff [4];
   logic [1:0]  jsel_ff;
   bb3_pkg::job_type cur_ff;

   logic        req_fire, csr_fire;
   logic        lastc, lastr;
   logic        out_free;
   logic        lane_go;
   logic [CW-1:0] x_in;
   logic [15:0]   y_in;

   always_comb begin
      if (width_ff == 11'd0) wmax = '0;
      else if (width_ff > 11'(bb3_pkg::MaxWidth)) wmax = CW'(bb3_pkg::MaxWidth - 1);
      else wmax = CW'(width_ff - 11'd1);
      hmax = (height_ff == 16'd0) ? 16'd0 : height_ff - 16'd1;
   end

   assign x_in  = (col_ff > wmax) ? wmax : col_ff;
   assign y_in  = (row_ff > hmax) ? hmax : row_ff;
   assign lastc = (x_in == wmax);
   assign lastr = (y_in == hmax);

   assign req.ready = !busy_ff && !csr.valid;
   assign csr.ready = 1'b1;
   assign req_fire  = req.valid && req.ready;
   assign csr_fire  = csr.valid;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         up_rd_ff  <= upper_mem[x_in[AW-1:0]];
         mid_rd_ff <= middle_mem[x_in[AW-1:0]];
         middle_mem[x_in[AW-1:0]] <= {req.in_blue, req.in_green, req.in_red};
         pix_ff  <= {req.in_blue, req.in_green, req.in_red};
         addr_ff <= x_in[AW-1:0];
      end
      if (shift_ff) begin
         upper_mem[addr_ff] <= mid_rd_ff;
      end
   end

   // job list for this pixel, in emission order
   logic [3:0]          due;
   bb3_pkg::job_type    j [4];
   logic [1:0]          rlo_a, rlo_b, clo_a, clo_b;
   always_comb begin
      rlo_a = (y_in >= 16'd2) ? 2'd0 : 2'd1;
      rlo_b = (y_in >= 16'd1) ? 2'd1 : 2'd2;
      clo_a = (x_in >= CW'(2)) ? 2'd0 : 2'd1;
      clo_b = (x_in >= CW'(1)) ? 2'd1 : 2'd2;
      due[0] = (y_in != 16'd0) && (x_in != '0);
      due[1] = (y_in != 16'd0) && lastc;
      due[2] = lastr && (x_in != '0);
      due[3] = lastr && lastc;
      j[0] = '{rlo: rlo_a, clo: clo_a, run_last: 1'b0, frame_end: 1'b0};
      j[1] = '{rlo: rlo_a, clo: clo_b, run_last: 1'b0, frame_end: 1'b0};
      j[2] = '{rlo: rlo_b, clo: clo_a, run_last: 1'b0, frame_end: 1'b0};
      j[3] = '{rlo: rlo_b, clo: clo_b, run_last: 1'b0, frame_end: 1'b1};
      for (int k = 0; k < 4; k++) begin
         j[k].run_last = due[k] && ((due >> (k + 1)) == 4'd0);
      end
   end

   logic [3:0] pend_masked;
   logic [1:0] next_sel;
   always_comb begin
      next_sel = 2'd0;
      for (int k = 3; k >= 0; k--) begin
         if (pend_ff[k]) next_sel = 2'(k);
      end
      pend_masked = pend_ff & ~(4'd1 << next_sel);
   end

   assign out_free = !rsp.valid || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         height_ff <= 16'd768;
         col_ff    <= '0;
         row_ff    <= '0;
         busy_ff   <= 1'b0;
         shift_ff  <= 1'b0;
         pend_ff   <= '0;
         calc_ff   <= 1'b0;
         for (int k = 0; k < 9; k++) win_ff[k] <= '0;
      end else begin
         calc_ff <= lane_go;
         if (csr_fire) begin
            if (csr.index == bb3_pkg::CSR_FRAME_WIDTH) width_ff <= csr.data[10:0];
            else height_ff <= csr.data;
            col_ff <= '0;
            row_ff <= '0;
         end else if (req_fire) begin
            busy_ff  <= 1'b1;
            shift_ff <= 1'b1;
            pend_ff  <= due;
            for (int k = 0; k < 4; k++) jobs_ff[k] <= j[k];
            if (lastc) begin
               col_ff <= '0;
               row_ff <= lastr ? 16'd0 : y_in + 16'd1;
            end else begin
               col_ff <= x_in + CW'(1);
               row_ff <= y_in;
            end
         end
         if (shift_ff) begin
            shift_ff <= 1'b0;
            for (int r = 0; r < 3; r++) begin
               win_ff[r * 3]     <= win_ff[r * 3 + 1];
               win_ff[r * 3 + 1] <= win_ff[r * 3 + 2];
            end
            win_ff[2] <= up_rd_ff;
            win_ff[5] <= mid_rd_ff;
            win_ff[8] <= pix_ff;
            if (pend_ff == 4'd0) busy_ff <= 1'b0;
         end else if (busy_ff && !calc_ff && !(rsp.valid && !rsp.ready && calc_ff)) begin
            if (pend_ff != 4'd0 && out_free) begin
               jsel_ff <= next_sel;
               cur_ff  <= jobs_ff[next_sel];
               pend_ff <= pend_masked;
            end else if (pend_ff == 4'd0) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   logic [7:0] wr [9], wg [9], wb [9];
   logic [7:0] mr, mg, mb;
   bb3_pkg::job_type sel_job;
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         wr[k] = win_ff[k][7:0];
         wg[k] = win_ff[k][15:8];
         wb[k] = win_ff[k][23:16];
      end
      sel_job = jobs_ff[next_sel];
   end
   assign lane_go = busy_ff && !shift_ff && !calc_ff && pend_ff != 4'd0 && out_free;

   bb3_lane u_red   (.clock, .start(lane_go), .win(wr), .rlo(sel_job.rlo),
                     .clo(sel_job.clo), .mean(mr));
   bb3_lane u_green (.clock, .start(lane_go), .win(wg), .rlo(sel_job.rlo),
                     .clo(sel_job.clo), .mean(mg));
   bb3_lane u_blue  (.clock, .start(lane_go), .win(wb), .rlo(sel_job.rlo),
                     .clo(sel_job.clo), .mean(mb));

   bb3_merge u_merge (.clock, .reset, .load(calc_ff), .red(mr), .green(mg), .blue(mb),
                      .job(cur_ff), .rsp);

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req.ready) else $error("pixel taken while busy");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      calc_ff |-> $past(out_free)) else $error("result overwrote pending word");
   a_sel_pending: assert property (@(posedge clock) disable iff (reset)
      calc_ff |-> (($past(pend_ff) & ~pend_ff) == (4'd1 << jsel_ff)))
      else $error("job not pending");
endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: box_blur_3x3_rgb testbench
// Streams small frames through the blur and predicts every output word with
// its own 3x3 window model. Frame size registers are rewritten between
// phases, with the extremes included. Both handshakes stall at random.
// ----------------------------------------------------------------------------

class blur_scoreboard;
   bb3_pkg::pixel_type  upper_row [bb3_pkg::MaxWidth];
   bb3_pkg::pixel_type  middle_row [bb3_pkg::MaxWidth];
   bb3_pkg::pixel_type  win [9];
   int unsigned row_pos, col_pos;
   logic [10:0] width_reg;
   logic [15:0] height_reg;
   bb3_pkg::result_type pending_px [$];
   int         errors;
   int         words_checked;

   function new();
      foreach (upper_row[i]) begin
         upper_row[i] = '0;
         middle_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      row_pos = 0;
      col_pos = 0;
      width_reg = 11'd1024;
      height_reg = 16'd768;
      errors = 0;
      words_checked = 0;
   endfunction

   function void write_reg(logic idx, logic [15:0] data);
      if (idx == bb3_pkg::CSR_FRAME_WIDTH) width_reg = data[10:0];
      else height_reg = data;
      row_pos = 0;
      col_pos = 0;
   endfunction

   function bb3_pkg::result_type window_mean(int rlo, int clo);
      int unsigned s [3];
      int unsigned n, v;
      bb3_pkg::result_type res;
      s = '{0, 0, 0};
      n = 0;
      for (int r = rlo; r < 3; r++)
         for (int c = clo; c < 3; c++) begin
            for (int ch = 0; ch < 3; ch++) s[ch] += win[r*3+c][8*ch +: 8];
            n++;
         end
      res = '0;
      for (int ch = 0; ch < 3; ch++) begin
         v = (2*s[ch] + n) / (2*n);
         if (v > 255) v = 255;
         if (ch == 0) res.red = v[7:0];
         else if (ch == 1) res.green = v[7:0];
         else res.blue = v[7:0];
      end
      return res;
   endfunction

   function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w, h, x, y, rlo;
      bb3_pkg::pixel_type pix, up, mid;
      bb3_pkg::result_type fresh [$];
      bb3_pkg::result_type res;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > bb3_pkg::MaxWidth) w = bb3_pkg::MaxWidth;
      h = (height_reg == 0) ? 1 : height_reg;
      x = (col_pos >= w) ? w - 1 : col_pos;
      y = (row_pos >= h) ? h - 1 : row_pos;
      pix = {b, g, r};
      up = upper_row[x];
      mid = middle_row[x];
      upper_row[x] = mid;
      middle_row[x] = pix;
      for (int i = 0; i < 3; i++) begin
         win[i*3] = win[i*3+1];
         win[i*3+1] = win[i*3+2];
      end
      win[2] = up;
      win[5] = mid;
      win[8] = pix;
      if (y >= 1) begin
         rlo = (y >= 2) ? 0 : 1;
         if (x >= 1) fresh.push_back(window_mean(rlo, (x >= 2) ? 0 : 1));
         if (x == w - 1) fresh.push_back(window_mean(rlo, (x >= 1) ? 1 : 2));
      end
      if (y == h - 1) begin
         rlo = (y >= 1) ? 1 : 2;
         if (x >= 1) fresh.push_back(window_mean(rlo, (x >= 2) ? 0 : 1));
         if (x == w - 1) begin
            res = window_mean(rlo, (x >= 1) ? 1 : 2);
            res.frame_end = 1'b1;
            fresh.push_back(res);
         end
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].run_last = 1'b1;
      foreach (fresh[i]) pending_px.push_back(fresh[i]);
      if (x == w - 1) begin
         col_pos = 0;
         row_pos = (y == h - 1) ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
         row_pos = y;
      end
   endfunction

   function void check_word(bb3_pkg::result_type got);
      bb3_pkg::result_type exp;
      if (pending_px.size() == 0) begin
         $error("unexpected output word");
         errors++;
         return;
      end
      exp = pending_px.pop_front();
      words_checked++;
      if (got.red !== exp.red) begin
         $error("out_red expected %0d actual %0d", exp.red, got.red); errors++;
      end
      if (got.green !== exp.green) begin
         $error("out_green expected %0d actual %0d", exp.green, got.green); errors++;
      end
      if (got.blue !== exp.blue) begin
         $error("out_blue expected %0d actual %0d", exp.blue, got.blue); errors++;
      end
      if (got.run_last !== exp.run_last) begin
         $error("run_last expected %0d actual %0d", exp.run_last, got.run_last); errors++;
      end
      if (got.frame_end !== exp.frame_end) begin
         $error("frame_end expected %0d actual %0d", exp.frame_end, got.frame_end);
         errors++;
      end
   endfunction
endclass

module tb;
   localparam int CycleLimit = 300000;
   localparam int DrainWait  = 40;

   logic clock;
   logic reset;
   int   cycle_cnt;
   int   pixels_sent;
   int   csr_writes;
   blur_scoreboard sb;

   bb3_req_if req ();
   bb3_rsp_if rsp ();
   bb3_csr_if csr ();

   box_blur_3x3_rgb u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit stall_now();
      if (cycle_cnt >= 600 && cycle_cnt < 1100) return 1'b0;
      return $urandom_range(99) < 30;
   endfunction

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= !stall_now();
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_word({rsp.out_red, rsp.out_green, rsp.out_blue,
                        rsp.run_last, rsp.frame_end});
   end

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while (stall_now()) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.in_red <= r;
      req.in_green <= g;
      req.in_blue <= b;
      do @(posedge clock); while (!req.ready);
      sb.note_pixel(r, g, b);
      pixels_sent++;
   endtask

   task automatic send_random_pixels(int count);
      for (int i = 0; i < count; i++)
         send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
      req.valid <= 1'b0;
   endtask

   task automatic drain();
      while (sb.pending_px.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] data);
      drain();
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= data;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      sb.write_reg(idx, data);
      csr_writes++;
   endtask

   task automatic set_frame(logic [15:0] w, logic [15:0] h);
      write_reg(bb3_pkg::CSR_FRAME_WIDTH, w);
      write_reg(bb3_pkg::CSR_FRAME_HEIGHT, h);
   endtask

   initial begin
      int w, h;
      sb = new();
      cycle_cnt = 0;
      pixels_sent = 0;
      csr_writes = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.in_red = '0;
      req.in_green = '0;
      req.in_blue = '0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: first row only, no output yet
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      req.valid <= 1'b0;
      // 1x1 frame: each pixel is its own mean
      set_frame(16'd1, 16'd1);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd128, 8'd1);
      req.valid <= 1'b0;
      // zero width and zero height act as one
      set_frame(16'd0, 16'd0);
      send_random_pixels(2);
      // oversize width clamps, high data bits ignored
      set_frame(16'hFFFF, 16'd2);
      send_random_pixels(4);
      // tall frame, all height bits set
      set_frame(16'd2, 16'hFFFF);
      send_random_pixels(6);
      // 3x3 full frame with saturating values, rounding at 9/6/4
      set_frame(16'd3, 16'd3);
      for (int i = 0; i < 9; i++)
         send_pixel((i % 2) ? 8'd255 : 8'd0, 8'd255, 8'd1);
      req.valid <= 1'b0;

      // random frames, mostly complete, some cut short by a register write
      while (pixels_sent < 195) begin
         w = $urandom_range(6, 1);
         h = $urandom_range(5, 1);
         set_frame(16'($urandom_range(65535)) & 16'hF800 | 16'(w), 16'(h));
         if ($urandom_range(9) < 2) send_random_pixels($urandom_range(w*h, 1));
         else send_random_pixels(w * h * $urandom_range(2, 1));
      end
      set_frame(16'd1024, 16'd768);
      drain();

      $display("Sent %0d pixels over %0d register writes, checked %0d output words.",
               pixels_sent, csr_writes, sb.words_checked);
      $display("Frames from 1x1 up to clamped full width, with random stalls.");
      if (sb.errors == 0 && sb.pending_px.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
